// ----- hw/rtl/dip_pkg.sv -----
`default_nettype none

package dip_pkg;

  // Parser phases.
  localparam logic [2:0] PH_START   = 3'd0;
  localparam logic [2:0] PH_WS      = 3'd1;
  localparam logic [2:0] PH_SIGN    = 3'd2;
  localparam logic [2:0] PH_DIGITS  = 3'd3;
  localparam logic [2:0] PH_HEXNEED = 3'd4;
  localparam logic [2:0] PH_SKIP    = 3'd5;

  // Radix of the current part.
  localparam logic [1:0] RX_DEC   = 2'd0;
  localparam logic [1:0] RX_OCT   = 2'd1;
  localparam logic [1:0] RX_HEX   = 2'd2;
  localparam logic [1:0] RX_LEAD0 = 2'd3;

  // Characters of interest.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;

  localparam logic [1:0] CLASS_B = 2'd2;

  typedef struct packed {
    logic [2:0]      phase;
    logic [2:0]      parts_done;
    logic [7:0]      part_value;
    logic            part_overflow;
    logic [1:0]      radix_mode;
    logic            negative_sign;
    logic [3:0][7:0] octets;
    logic            rejected;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:         PH_START,
    parts_done:    3'd0,
    part_value:    8'd0,
    part_overflow: 1'b0,
    radix_mode:    RX_DEC,
    negative_sign: 1'b0,
    octets:        '0,
    rejected:      1'b0
  };

  typedef struct packed {
    logic [31:0] ip_address;
    logic        valid_res;
  } dip_result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  // Returns {is_digit, value} for the character in the given radix mode.
  function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] mode);
    logic [4:0] base;
    logic [3:0] d;
    logic       hit;
    begin
      base = (mode == RX_HEX) ? 5'd16 : ((mode == RX_DEC) ? 5'd10 : 5'd8);
      hit  = 1'b1;
      d    = 4'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = 4'(c - CH_ZERO);
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = 4'(c - CH_LA + 8'd10);
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = 4'(c - CH_UA + 8'd10);
      end else begin
        hit = 1'b0;
      end
      return {hit && ({1'b0, d} < base), d};
    end
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dotted_ipv4_address_parser.sv -----
`default_nettype none

// Dotted IPv4 address parser. Takes the address text one character per word on
// the input stream, ended by a zero character, and returns one word per string:
// the 32-bit address (first octet in the top byte) in out_tdata and a valid flag
// in out_tuser; rejected text gives address 0 with the flag low. Parts are read
// in decimal, octal (leading 0) or hex (0x), and classful short forms with two
// or three parts are expanded. One character is accepted every cycle unless a
// terminating zero is held; the parser state update for one character sits
// between the input register and the output register, which takes the result
// as that zero moves on. A terminating zero waits in the input register, and
// holds off further characters, while an earlier result has not been taken.
module dotted_ipv4_address_parser
  import dip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] ch
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [31:0] out_tdata,  // [31:0] ip_address
  output      logic        out_tuser   // [0] valid_res
);

  logic        in_v_r;
  logic [7:0]  in_ch_r;
  logic        adv;
  logic        fin;
  logic        out_v_r;
  dip_result_t out_r;
  dip_result_t res;

  assign fin = (in_ch_r == CH_NUL);
  // A character moves on unless it ends a string whose result cannot be stored.
  assign adv       = in_v_r && (!fin || !out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;

  dip_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .ch    (in_ch_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && fin) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && fin) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_r.ip_address;
  assign out_tuser  = out_r.valid_res;

endmodule

`default_nettype wire

// ----- hw/rtl/dip_parser.sv -----
`default_nettype none

module dip_parser
  import dip_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic [7:0]  ch,
  output dip_result_t      res
);

  parse_state_t st_r;
  parse_state_t st_nxt;
  logic         fin;

  // Multiply-accumulate of one digit, saturating at 255 with an overflow flag.
  function automatic parse_state_t accumulate(input parse_state_t s, input logic [3:0] d);
    parse_state_t o;
    logic [11:0]  v;
    logic [11:0]  pv;
    begin
      o  = s;
      pv = {4'd0, s.part_value};
      case (s.radix_mode)
        RX_HEX:  v = (pv << 4) + {8'd0, d};
        RX_DEC:  v = (pv << 3) + (pv << 1) + {8'd0, d};
        default: v = (pv << 3) + {8'd0, d};
      endcase
      if (v > 12'd255) begin
        o.part_overflow = 1'b1;
        o.part_value    = 8'hff;
      end else begin
        o.part_value = v[7:0];
      end
      return o;
    end
  endfunction

  function automatic parse_state_t end_part(input parse_state_t s, input logic at_dot);
    parse_state_t o;
    begin
      o = s;
      if (s.part_overflow || (s.negative_sign && s.part_value != 8'd0)) begin
        o.rejected = 1'b1;
      end else begin
        o.octets[s.parts_done[1:0]] = s.part_value;
        o.parts_done    = s.parts_done + 3'd1;
        o.part_value    = 8'd0;
        o.part_overflow = 1'b0;
        o.radix_mode    = RX_DEC;
        o.negative_sign = 1'b0;
        o.phase = (at_dot && s.parts_done >= 3'd3) ? PH_SKIP : PH_START;
      end
      return o;
    end
  endfunction

  assign fin = (ch == CH_NUL);

  always_comb begin
    logic [4:0] dg;
    logic [4:0] hx;
    st_nxt = st_r;
    dg     = digit_of(ch, st_r.radix_mode == RX_LEAD0 ? RX_OCT : st_r.radix_mode);
    hx     = digit_of(ch, RX_HEX);
    if (!st_r.rejected) begin
      case (st_r.phase)
        PH_START, PH_WS: begin
          if (is_space(ch)) begin
            st_nxt.phase = PH_WS;
          end else if (ch == CH_PLUS || ch == CH_MINUS) begin
            st_nxt.negative_sign = (ch == CH_MINUS);
            st_nxt.phase         = PH_SIGN;
          end else if (ch == CH_ZERO) begin
            st_nxt.radix_mode = RX_LEAD0;
            st_nxt.phase      = PH_DIGITS;
          end else if (ch >= CH_ONE && ch <= CH_NINE) begin
            st_nxt.radix_mode = RX_DEC;
            st_nxt.part_value = ch - CH_ZERO;
            st_nxt.phase      = PH_DIGITS;
          end else if (st_r.phase == PH_START && ch == CH_DOT) begin
            st_nxt = end_part(st_r, 1'b1);
          end else if (!(st_r.phase == PH_START && fin)) begin
            st_nxt.rejected = 1'b1;
          end
        end
        PH_SIGN: begin
          if (ch == CH_ZERO) begin
            st_nxt.radix_mode = RX_LEAD0;
            st_nxt.phase      = PH_DIGITS;
          end else if (ch >= CH_ONE && ch <= CH_NINE) begin
            st_nxt.radix_mode = RX_DEC;
            st_nxt.part_value = ch - CH_ZERO;
            st_nxt.phase      = PH_DIGITS;
          end else begin
            st_nxt.rejected = 1'b1;
          end
        end
        PH_HEXNEED: begin
          if (!hx[4]) begin
            st_nxt.rejected = 1'b1;
          end else begin
            st_nxt.radix_mode = RX_HEX;
            st_nxt            = accumulate(st_nxt, hx[3:0]);
            st_nxt.phase      = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          if (st_r.radix_mode == RX_LEAD0 && (ch == CH_LX || ch == CH_UX)) begin
            st_nxt.phase = PH_HEXNEED;
          end else if (dg[4]) begin
            if (st_r.radix_mode == RX_LEAD0) begin
              st_nxt.radix_mode = RX_OCT;
            end
            st_nxt = accumulate(st_nxt, dg[3:0]);
          end else if (ch == CH_DOT || fin) begin
            st_nxt = end_part(st_r, ch == CH_DOT);
          end else begin
            st_nxt.rejected = 1'b1;
          end
        end
        PH_SKIP: begin
        end
        default: begin
          st_nxt.rejected = 1'b1;
        end
      endcase
    end
  end

  // Classful expansion of the finished string.
  always_comb begin
    logic [7:0] a, b, x, y;
    logic [2:0] n;
    logic       ok;
    n  = st_nxt.parts_done;
    a  = st_nxt.octets[0];
    b  = st_nxt.octets[1];
    x  = st_nxt.octets[2];
    y  = st_nxt.octets[3];
    ok = !st_nxt.rejected && (n != 3'd0);
    if (ok && n != 3'd4) begin
      if (!a[7] && n == 3'd3) begin
        y = x;
        x = b;
        b = 8'd0;
      end else if (!a[7] && n == 3'd2) begin
        y = b;
        x = 8'd0;
        b = 8'd0;
      end else if (a[7:6] == CLASS_B && n == 3'd3) begin
        y = x;
        x = 8'd0;
      end else begin
        ok = 1'b0;
      end
    end
    res.ip_address = ok ? {a, b, x, y} : 32'd0;
    res.valid_res  = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= STATE_RESET;
    end else if (step) begin
      st_r <= fin ? STATE_RESET : st_nxt;
    end
  end

endmodule

`default_nettype wire
